@@ design/spr_pkg.sv @@
package spr_pkg;

  localparam int NODE_W = 6;
  localparam int WEIGHT_W = 16;
  localparam int SUM_W = 32;
  localparam int CMD_W = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_W = 7;

  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd64;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_NODE = 2'd2;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [NODE_W-1:0] edge_source;
    logic [NODE_W-1:0] edge_dest;
    logic [WEIGHT_W-1:0] edge_speed;
    logic [WEIGHT_W-1:0] edge_length;
    logic [NODE_W-1:0] start_node;
    logic [NODE_W-1:0] goal_node;
  } spr_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic reachable;
    logic [SUM_W-1:0] path_distance;
    logic [SUM_W-1:0] path_speed;
  } spr_result_t;

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [WEIGHT_W-1:0] speed;
    logic [WEIGHT_W-1:0] length;
  } spr_edge_t;

  typedef struct packed {
    logic reached;
    logic [SUM_W-1:0] distance;
    logic [SUM_W-1:0] speed;
  } spr_node_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SWEEP,
    S_SCAN,
    S_ORD,
    S_EDGE,
    S_NODE,
    S_UPD,
    S_GOAL,
    S_DONE
  } spr_state_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [WEIGHT_W-1:0] b);
    logic [SUM_W:0] sum;
    sum = {1'b0, a} + {{(SUM_W + 1 - WEIGHT_W){1'b0}}, b};
    return sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
  endfunction

endpackage

@@ design/shortest_path_relaxation.sv @@
// Shortest-path relaxation engine. Edges are appended one per beat (add) and
// the table is emptied by a clear beat; both answer in the cycle after
// acceptance. A query first initialises the node table (n = clamped
// node_count), then builds a source-ordered edge list by scanning the edge
// store once per node, then runs n-1 relaxation passes over the m listed
// edges, each edge going through list read, edge read, node reads and update
// in the single shared add-and-compare unit and the node memory, and finally
// reads the goal entry. The block takes no new beat while a query runs.
// Unused edge or node memory entries are never read, so no clearing pass
// follows reset.
module shortest_path_relaxation #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  spr_pkg::spr_item_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output spr_pkg::spr_result_t result,
  input  logic                 cfg_write_en,
  input  logic [6:0]           cfg_write_data
);

  import spr_pkg::*;

  localparam int NAW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW1 = $clog2(MAX_EDGES + 1);

  spr_state_t state, state_next;

  logic [CFG_W-1:0] node_count;
  logic [EW1-1:0]   edge_total;
  logic [CW-1:0]    n_use;

  logic        item_acc;
  logic        edge_ok;
  logic        query_ok;
  logic        table_full;
  spr_result_t imm_result;

  logic [NAW-1:0] start_q;
  logic [NAW-1:0] goal_q;
  logic [CW-1:0]  sweep;
  logic           sweep_last;
  logic           scan_issue;
  logic [CW-1:0]  scan_u;
  logic [EW1-1:0] scan_e;
  logic           chk_valid;
  logic [CW-1:0]  chk_u;
  logic [EW1-1:0] chk_e;
  logic           chk_match;
  logic [EW1-1:0] ord_count;
  logic [EW1-1:0] k;
  logic [CW-1:0]  pass;
  logic           k_last;
  logic           pass_last;

  logic           edge_wr_en;
  logic [EAW-1:0] edge_wr_addr;
  spr_edge_t      edge_wr_data;
  logic           edge_rd_en;
  logic [EAW-1:0] edge_rd_addr;
  spr_edge_t      edge_q;

  logic           ord_wr_en;
  logic           ord_rd_en;
  logic [EAW-1:0] ord_q;

  logic           node_wr_en;
  logic [NAW-1:0] node_wr_addr;
  spr_node_t      node_wr_data;
  logic           node_a_en;
  logic [NAW-1:0] node_a_addr;
  spr_node_t      node_a_q;
  logic           node_b_en;
  spr_node_t      node_b_q;

  logic      relax_update;
  spr_node_t relaxed;

  always_comb begin
    if (node_count == '0) begin
      n_use = CW'(1);
    end else if (32'(node_count) > MAX_NODES) begin
      n_use = CW'(MAX_NODES);
    end else begin
      n_use = CW'(node_count);
    end
  end

  assign item_stall = !((state == S_IDLE) && (!result_valid || !result_stall));
  assign item_acc = item_valid && !item_stall;
  assign edge_ok = (32'(item.edge_source) < 32'(n_use)) && (32'(item.edge_dest) < 32'(n_use));
  assign query_ok = (32'(item.start_node) < 32'(n_use)) && (32'(item.goal_node) < 32'(n_use));
  assign table_full = 32'(edge_total) >= MAX_EDGES;

  assign sweep_last = (sweep + 1'b1) == n_use;
  assign chk_match = chk_valid && (32'(edge_q.src) == 32'(chk_u)) &&
                     (32'(edge_q.dst) < 32'(n_use));
  assign k_last = (k + 1'b1) == ord_count;
  assign pass_last = (pass + 1'b1) == n_use;

  always_comb begin
    imm_result = '0;
    case (item.cmd)
      CMD_ADD: begin
        if (!edge_ok) begin
          imm_result.status = ST_BAD_NODE;
        end else if (table_full) begin
          imm_result.status = ST_FULL;
        end
      end
      CMD_QUERY: begin
        if (!query_ok) begin
          imm_result.status = ST_BAD_NODE;
        end
      end
      default: imm_result.status = ST_OK;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_acc && (item.cmd == CMD_QUERY) && query_ok) begin
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (sweep_last) begin
          if ((edge_total == '0) || (n_use == CW'(1))) begin
            state_next = S_GOAL;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!scan_issue && !chk_valid) begin
          state_next = (ord_count == '0) ? S_GOAL : S_ORD;
        end
      end
      S_ORD:  state_next = S_EDGE;
      S_EDGE: state_next = S_NODE;
      S_NODE: state_next = S_UPD;
      S_UPD:  state_next = (k_last && pass_last) ? S_GOAL : S_ORD;
      S_GOAL: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    edge_wr_en = 1'b0;
    edge_wr_addr = edge_total[EAW-1:0];
    edge_wr_data = '{src: item.edge_source, dst: item.edge_dest,
                     speed: item.edge_speed, length: item.edge_length};
    edge_rd_en = 1'b0;
    edge_rd_addr = scan_e[EAW-1:0];
    ord_wr_en = 1'b0;
    ord_rd_en = 1'b0;
    node_wr_en = 1'b0;
    node_wr_addr = sweep[NAW-1:0];
    node_wr_data = '{reached: (sweep[NAW-1:0] == start_q), distance: '0, speed: '0};
    node_a_en = 1'b0;
    node_a_addr = NAW'(edge_q.src);
    node_b_en = 1'b0;
    unique case (state)
      S_IDLE: begin
        edge_wr_en = item_acc && (item.cmd == CMD_ADD) && edge_ok && !table_full;
      end
      S_SWEEP: begin
        node_wr_en = 1'b1;
      end
      S_SCAN: begin
        edge_rd_en = scan_issue;
        ord_wr_en = chk_match;
      end
      S_ORD: begin
        ord_rd_en = 1'b1;
      end
      S_EDGE: begin
        edge_rd_en = 1'b1;
        edge_rd_addr = ord_q;
      end
      S_NODE: begin
        node_a_en = 1'b1;
        node_b_en = 1'b1;
      end
      S_UPD: begin
        node_wr_en = relax_update;
        node_wr_addr = NAW'(edge_q.dst);
        node_wr_data = relaxed;
      end
      S_GOAL: begin
        node_a_en = 1'b1;
        node_a_addr = goal_q;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      node_count <= NODE_COUNT_RESET;
      edge_total <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        node_count <= cfg_write_data;
      end
      if (edge_wr_en) begin
        edge_total <= edge_total + 1'b1;
      end else if (item_acc && (item.cmd == CMD_CLEAR)) begin
        edge_total <= '0;
      end
      if ((item_acc && !((item.cmd == CMD_QUERY) && query_ok)) || (state == S_DONE)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      start_q <= NAW'(item.start_node);
      goal_q <= NAW'(item.goal_node);
      sweep <= '0;
      result <= imm_result;
    end
    if (state == S_SWEEP) begin
      sweep <= sweep + 1'b1;
      scan_issue <= 1'b1;
      scan_u <= '0;
      scan_e <= '0;
      chk_valid <= 1'b0;
      ord_count <= '0;
      pass <= CW'(1);
      k <= '0;
    end
    if (state == S_SCAN) begin
      chk_valid <= scan_issue;
      chk_u <= scan_u;
      chk_e <= scan_e;
      if (scan_issue) begin
        if ((scan_e + 1'b1) == edge_total) begin
          scan_e <= '0;
          if ((scan_u + 1'b1) == n_use) begin
            scan_issue <= 1'b0;
          end else begin
            scan_u <= scan_u + 1'b1;
          end
        end else begin
          scan_e <= scan_e + 1'b1;
        end
      end
      if (chk_match) begin
        ord_count <= ord_count + 1'b1;
      end
    end
    if (state == S_UPD) begin
      if (k_last) begin
        k <= '0;
        pass <= pass + 1'b1;
      end else begin
        k <= k + 1'b1;
      end
    end
    if (state == S_DONE) begin
      result.status <= ST_OK;
      result.reachable <= node_a_q.reached;
      result.path_distance <= node_a_q.reached ? node_a_q.distance : '0;
      result.path_speed <= node_a_q.reached ? node_a_q.speed : '0;
    end
  end

  spr_ram #(
    .WIDTH($bits(spr_edge_t)),
    .DEPTH(MAX_EDGES),
    .AW(EAW)
  ) u_edge_ram (
    .clk(clk),
    .wr_en(edge_wr_en),
    .wr_addr(edge_wr_addr),
    .wr_data(edge_wr_data),
    .rd_en(edge_rd_en),
    .rd_addr(edge_rd_addr),
    .rd_data(edge_q)
  );

  spr_ram #(
    .WIDTH(EAW),
    .DEPTH(MAX_EDGES),
    .AW(EAW)
  ) u_ord_ram (
    .clk(clk),
    .wr_en(ord_wr_en),
    .wr_addr(ord_count[EAW-1:0]),
    .wr_data(chk_e[EAW-1:0]),
    .rd_en(ord_rd_en),
    .rd_addr(k[EAW-1:0]),
    .rd_data(ord_q)
  );

  spr_node_ram #(
    .DEPTH(MAX_NODES),
    .AW(NAW)
  ) u_node_ram (
    .clk(clk),
    .wr_en(node_wr_en),
    .wr_addr(node_wr_addr),
    .wr_data(node_wr_data),
    .rd_a_en(node_a_en),
    .rd_a_addr(node_a_addr),
    .rd_a_data(node_a_q),
    .rd_b_en(node_b_en),
    .rd_b_addr(NAW'(edge_q.dst)),
    .rd_b_data(node_b_q)
  );

  spr_relax u_relax (
    .src_node(node_a_q),
    .dst_node(node_b_q),
    .edge_word(edge_q),
    .update(relax_update),
    .relaxed(relaxed)
  );

  a_done_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> !result_valid)
    else $error("query result would overwrite a pending result");

  a_bad_query: assert property (@(posedge clk) disable iff (rst)
    item_acc && (item.cmd == CMD_QUERY) && !query_ok |=>
      result_valid && (result.status == ST_BAD_NODE) && (state == S_IDLE))
    else $error("rejected query not answered at once");

  a_list_index: assert property (@(posedge clk) disable iff (rst)
    state == S_ORD |-> (k < ord_count) && (ord_count <= edge_total))
    else $error("edge list index out of range");

  a_full_table: assert property (@(posedge clk) disable iff (rst)
    item_acc && (item.cmd == CMD_ADD) && (32'(edge_total) == MAX_EDGES) |=>
      edge_total == $past(edge_total))
    else $error("edge stored into a full table");

endmodule

@@ design/spr_ram.sv @@
module spr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/spr_node_ram.sv @@
module spr_node_ram #(
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  spr_pkg::spr_node_t wr_data,
  input  logic              rd_a_en,
  input  logic [AW-1:0]     rd_a_addr,
  output spr_pkg::spr_node_t rd_a_data,
  input  logic              rd_b_en,
  input  logic [AW-1:0]     rd_b_addr,
  output spr_pkg::spr_node_t rd_b_data
);

  import spr_pkg::*;

  spr_node_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_a_en) begin
      rd_a_data <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_data <= mem[rd_b_addr];
    end
  end

endmodule

@@ design/spr_relax.sv @@
module spr_relax (
  input  spr_pkg::spr_node_t src_node,
  input  spr_pkg::spr_node_t dst_node,
  input  spr_pkg::spr_edge_t edge_word,
  output logic               update,
  output spr_pkg::spr_node_t relaxed
);

  import spr_pkg::*;

  logic [SUM_W-1:0] new_distance;
  logic [SUM_W-1:0] new_speed;

  always_comb begin
    new_distance = sat_add(src_node.distance, edge_word.length);
    new_speed = sat_add(src_node.speed, edge_word.speed);
    relaxed.reached = 1'b1;
    relaxed.distance = new_distance;
    relaxed.speed = new_speed;
    update = src_node.reached &&
             (!dst_node.reached || (new_distance < dst_node.distance) ||
              ((new_distance == dst_node.distance) && (new_speed > dst_node.speed)));
  end

endmodule

@@ dv/shortest_path_relaxation_test.sv @@
`timescale 1ns / 100ps

module shortest_path_relaxation_test;
  import spr_pkg::*;

  localparam int NODE_SLOTS = 64;
  localparam int EDGE_SLOTS = 256;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  class route_scoreboard;
    logic [CFG_W-1:0] node_limit = NODE_COUNT_RESET;
    spr_edge_t link_table [EDGE_SLOTS];
    int unsigned link_total = 0;
    logic [SUM_W-1:0] best_len [NODE_SLOTS];
    logic [SUM_W-1:0] best_speed [NODE_SLOTS];
    bit touched [NODE_SLOTS];
    spr_result_t awaited_routes [$];
    int unsigned faults = 0;
    int unsigned checked = 0;

    function int unsigned active_nodes();
      if (node_limit == 0) return 1;
      if (node_limit > NODE_SLOTS) return NODE_SLOTS;
      return 32'(node_limit);
    endfunction

    function logic [SUM_W-1:0] add_clamped(logic [SUM_W-1:0] acc, logic [WEIGHT_W-1:0] w);
      logic [SUM_W:0] total;
      total = {1'b0, acc} + (SUM_W + 1)'(w);
      if (total[SUM_W]) return '1;
      return total[SUM_W-1:0];
    endfunction

    function void relax_from(int unsigned n, int unsigned origin);
      logic [SUM_W-1:0] cand_len;
      logic [SUM_W-1:0] cand_speed;
      int unsigned v;
      for (int k = 0; k < NODE_SLOTS; k++) begin
        best_len[k] = '0;
        best_speed[k] = '0;
        touched[k] = 1'b0;
      end
      touched[origin] = 1'b1;
      for (int unsigned p = 1; p < n; p++) begin
        for (int unsigned u = 0; u < n; u++) begin
          if (!touched[u]) continue;
          for (int unsigned e = 0; e < link_total; e++) begin
            if (link_table[e].src != u || link_table[e].dst >= n) continue;
            v = 32'(link_table[e].dst);
            cand_len = add_clamped(best_len[u], link_table[e].length);
            cand_speed = add_clamped(best_speed[u], link_table[e].speed);
            if (!touched[v] || cand_len < best_len[v] ||
                (cand_len == best_len[v] && cand_speed > best_speed[v])) begin
              best_len[v] = cand_len;
              best_speed[v] = cand_speed;
              touched[v] = 1'b1;
            end
          end
        end
      end
    endfunction

    function spr_result_t route_outcome(spr_item_t it);
      spr_result_t res;
      int unsigned n;
      res = '0;
      res.status = ST_OK;
      n = active_nodes();
      case (it.cmd)
        CMD_ADD: begin
          if (it.edge_source >= n || it.edge_dest >= n) begin
            res.status = ST_BAD_NODE;
          end else if (link_total >= EDGE_SLOTS) begin
            res.status = ST_FULL;
          end else begin
            link_table[link_total].src = it.edge_source;
            link_table[link_total].dst = it.edge_dest;
            link_table[link_total].speed = it.edge_speed;
            link_table[link_total].length = it.edge_length;
            link_total++;
          end
        end
        CMD_QUERY: begin
          if (it.start_node >= n || it.goal_node >= n) begin
            res.status = ST_BAD_NODE;
          end else begin
            relax_from(n, 32'(it.start_node));
            if (touched[it.goal_node]) begin
              res.reachable = 1'b1;
              res.path_distance = best_len[it.goal_node];
              res.path_speed = best_speed[it.goal_node];
            end
          end
        end
        CMD_CLEAR: link_total = 0;
        default: ;
      endcase
      return res;
    endfunction

    function void note_item(spr_item_t it);
      spr_result_t want;
      want = route_outcome(it);
      awaited_routes = {awaited_routes, want};
    endfunction

    function void check_result(spr_result_t got);
      spr_result_t want;
      checked++;
      if (awaited_routes.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("result %0d unexpected: status %0d reach %0d len %0d speed %0d",
                   checked, got.status, got.reachable, got.path_distance, got.path_speed);
        return;
      end
      want = awaited_routes.pop_front();
      if (got.status !== want.status || got.reachable !== want.reachable ||
          got.path_distance !== want.path_distance || got.path_speed !== want.path_speed) begin
        faults++;
        if (faults <= 10)
          $display("result %0d mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                   checked, want.status, want.reachable, want.path_distance,
                   want.path_speed, got.status, got.reachable, got.path_distance,
                   got.path_speed);
      end
    endfunction

    function int unsigned pending();
      return awaited_routes.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  spr_item_t beat_in = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  spr_result_t beat_out;
  logic cfg_write_en = 1'b0;
  logic [CFG_W-1:0] cfg_write_data = '0;

  int unsigned send_gap_pct = 28;
  int unsigned recv_stall_pct = 55;
  int unsigned cycle_count = 0;
  route_scoreboard board;

  shortest_path_relaxation dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(beat_in),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(beat_out),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) board.note_item(beat_in);
    if (!rst && result_valid && !result_stall) board.check_result(beat_out);
  end

  function automatic spr_item_t noise_beat();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[$bits(spr_item_t)-1:0];
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return WEIGHT_W'($urandom_range(7));
      default: return WEIGHT_W'($urandom());
    endcase
  endfunction

  function automatic spr_item_t add_beat(int unsigned s, int unsigned d,
                                         int unsigned spd, int unsigned len);
    spr_item_t it;
    it = noise_beat();
    it.cmd = CMD_ADD;
    it.edge_source = NODE_W'(s);
    it.edge_dest = NODE_W'(d);
    it.edge_speed = WEIGHT_W'(spd);
    it.edge_length = WEIGHT_W'(len);
    return it;
  endfunction

  function automatic spr_item_t query_beat(int unsigned s, int unsigned g);
    spr_item_t it;
    it = noise_beat();
    it.cmd = CMD_QUERY;
    it.start_node = NODE_W'(s);
    it.goal_node = NODE_W'(g);
    return it;
  endfunction

  function automatic spr_item_t plain_beat(logic [CMD_W-1:0] c);
    spr_item_t it;
    it = noise_beat();
    it.cmd = c;
    return it;
  endfunction

  function automatic spr_item_t random_beat(int unsigned n);
    spr_item_t it;
    int unsigned pick;
    it = noise_beat();
    pick = $urandom_range(99);
    if (pick < 55) begin
      it.cmd = CMD_ADD;
      if ($urandom_range(9) != 0) begin
        it.edge_source = NODE_W'($urandom_range(n - 1));
        it.edge_dest = NODE_W'($urandom_range(n - 1));
      end
      it.edge_speed = rand_weight();
      it.edge_length = rand_weight();
    end else if (pick < 85) begin
      it.cmd = CMD_QUERY;
      if ($urandom_range(9) != 0) begin
        it.start_node = NODE_W'($urandom_range(n - 1));
        it.goal_node = NODE_W'($urandom_range(n - 1));
      end
    end else if (pick < 90) begin
      it.cmd = CMD_CLEAR;
    end else begin
      it.cmd = CMD_SPARE;
    end
    return it;
  endfunction

  task automatic send_beat(input spr_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    beat_in <= it;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_node_count(input int unsigned value);
    settle();
    cfg_write_en <= 1'b1;
    cfg_write_data <= CFG_W'(value);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    board.node_limit = CFG_W'(value);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_beat(random_beat(board.active_nodes()));
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("shortest_path_relaxation regression: fail");
    $finish;
  end

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_beat(query_beat(0, 63));
    send_beat(query_beat(5, 5));
    send_beat(add_beat(0, 63, '1, '1));
    send_beat(query_beat(0, 63));
    send_beat(add_beat(0, 1, 1, 10));
    send_beat(add_beat(1, 63, 2, 65525));
    send_beat(add_beat(0, 2, 40000, 5));
    send_beat(add_beat(2, 63, 40000, 65530));
    send_beat(query_beat(0, 63));
    send_beat(add_beat(0, 3, 7, 0));
    send_beat(add_beat(3, 0, 9, 0));
    send_beat(query_beat(0, 0));
    send_beat(add_beat(63, 63, '1, '1));
    send_beat(add_beat(0, 0, '0, '0));
    send_beat(plain_beat(CMD_SPARE));
    send_beat(add_beat(0, 40, 3, 1));
    send_beat(add_beat(40, 5, 3, 1));
    send_beat(add_beat(0, 5, 1, 100));
    send_beat(query_beat(0, 5));

    set_node_count(8);
    send_beat(query_beat(0, 5));
    send_beat(add_beat(8, 0, 1, 1));
    send_beat(add_beat(0, 8, 1, 1));
    send_beat(query_beat(8, 0));
    send_beat(query_beat(0, 8));

    set_node_count(0);
    send_beat(query_beat(0, 0));
    send_beat(add_beat(0, 1, 5, 5));
    send_beat(add_beat(0, 0, 5, 5));
    send_beat(query_beat(0, 0));

    set_node_count(127);
    send_beat(query_beat(0, 63));
    send_beat(plain_beat(CMD_CLEAR));
    send_beat(query_beat(0, 63));

    // fill the edge table on a two-node graph
    set_node_count(2);
    send_beat(plain_beat(CMD_CLEAR));
    repeat (EDGE_SLOTS)
      send_beat(add_beat($urandom_range(1), $urandom_range(1),
                         32'(rand_weight()), 32'(rand_weight())));
    send_beat(add_beat(1, 0, 1, 1));
    send_beat(add_beat(2, 0, 1, 1));
    send_beat(query_beat(0, 1));
    set_node_count(1);
    send_beat(query_beat(0, 0));
    send_beat(add_beat(0, 0, 1, 1));
    set_node_count(64);
    send_beat(query_beat(0, 1));

    send_gap_pct = 55;
    recv_stall_pct = 28;
    send_beat(plain_beat(CMD_CLEAR));
    run_random(15);
    set_node_count(6);
    send_beat(plain_beat(CMD_CLEAR));
    run_random(30);

    send_gap_pct = 0;
    recv_stall_pct = 0;
    set_node_count(12);
    send_beat(plain_beat(CMD_CLEAR));
    run_random(30);
    set_node_count(3);
    send_beat(plain_beat(CMD_CLEAR));
    run_random(25);

    settle();
    repeat (40) @(posedge clk);
    if (board.faults == 0 && board.pending() == 0) begin
      $display("shortest_path_relaxation regression: pass");
    end else begin
      $display("shortest_path_relaxation regression: fail");
    end
    $finish;
  end

endmodule
